### hw/rtl/etok_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etok_pkg
// Shared types, character codes and token kinds for the expression tokenizer.
// ----------------------------------------------------------------------------
package etok_pkg;

    localparam int TOK_W  = 13;
    localparam int QDEPTH = 4;

    typedef enum logic [3:0] {
        KIND_ERROR  = 4'd0,
        KIND_IDENT  = 4'd1,
        KIND_NUMBER = 4'd2,
        KIND_ADD    = 4'd3,
        KIND_SUB    = 4'd4,
        KIND_MUL    = 4'd5,
        KIND_DIV    = 4'd6,
        KIND_MOD    = 4'd7,
        KIND_OPEN   = 4'd8,
        KIND_CLOSE  = 4'd9,
        KIND_SEMI   = 4'd10,
        KIND_EQUAL  = 4'd11,
        KIND_EXIT   = 4'd12,
        KIND_CLEAR  = 4'd13,
        KIND_END    = 4'd14
    } t_kind;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    typedef struct packed {
        t_kind              kind;
        logic [TOK_W-1:0]   start;
        logic [TOK_W-1:0]   length;
    } t_token;

    // tok_a is the closed run when two tokens come from one character;
    // tok_b is always the final token of the character.
    typedef struct packed {
        logic   two;
        t_token tok_a;
        t_token tok_b;
    } t_entry;

    typedef struct packed {
        logic   empty;
        t_entry head;
    } t_qstat;

    function automatic logic [7:0] exit_char(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0:    c = 8'h65;
            2'd1:    c = 8'h78;
            2'd2:    c = 8'h69;
            default: c = 8'h74;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] clear_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h63;
            3'd1:    c = 8'h6C;
            3'd2:    c = 8'h65;
            3'd3:    c = 8'h61;
            3'd4:    c = 8'h72;
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic t_kind single_kind(input logic [7:0] c);
        t_kind k;
        unique case (c)
            CH_SEMI: k = KIND_SEMI;
            8'h28:   k = KIND_OPEN;
            8'h29:   k = KIND_CLOSE;
            8'h2B:   k = KIND_ADD;
            8'h2D:   k = KIND_SUB;
            8'h2A:   k = KIND_MUL;
            8'h2F:   k = KIND_DIV;
            8'h25:   k = KIND_MOD;
            8'h3D:   k = KIND_EQUAL;
            default: k = KIND_ERROR;
        endcase
        return k;
    endfunction

endpackage

### hw/rtl/expression_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// expression_tokenizer
// Streaming lexer for a small calculator language: characters in, tokens out.
// ----------------------------------------------------------------------------
// The block takes one text character per cycle and sends tokens as kind,
// start offset and length, one token per output transaction. A character
// that both closes a number or identifier and forms a token of its own, or
// ends the text, gives two tokens; o_last_of_run marks the last token of
// each character. Character 0, or the character at offset TEXT_DEPTH-1,
// ends the text with an end token and restarts the offsets at zero. The
// scanner registers its mode on each accepted character, so input runs at
// one character per cycle while o_stall is low; the output port moves one
// token per cycle while i_stall is low. A four-entry token queue between
// scanner and output register absorbs two-token characters and output
// stalls; each token passes through it and then the output register.
// ----------------------------------------------------------------------------
module expression_tokenizer #(
    parameter int TEXT_DEPTH = 8192
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_ch,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_token_kind,
    output logic [12:0] o_token_start,
    output logic [12:0] o_token_length,
    output logic        o_last_of_run
);

    logic             q_full;
    logic             push;
    logic             pop;
    etok_pkg::t_entry entry;
    etok_pkg::t_qstat qstat;
    etok_pkg::t_token tok;

    etok_front #(
        .TEXT_DEPTH (TEXT_DEPTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_ch     (i_ch),
        .i_q_full (q_full),
        .o_push   (push),
        .o_entry  (entry)
    );

    etok_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_stat  (qstat)
    );

    etok_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (qstat),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_tok   (tok),
        .o_last  (o_last_of_run)
    );

    assign o_token_kind   = tok.kind;
    assign o_token_start  = tok.start;
    assign o_token_length = tok.length;

endmodule

### hw/rtl/etok_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etok_front
// Scanner: takes one character per cycle unless the queue is full, keeps the
// scan mode and pushes the tokens the character closes or opens to the queue.
// ----------------------------------------------------------------------------
module etok_front #(
    parameter int TEXT_DEPTH = 8192
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [7:0]             i_ch,
    input  logic                   i_q_full,
    output logic                   o_push,
    output etok_pkg::t_entry       o_entry
);

    localparam int PW = $clog2(TEXT_DEPTH);
    localparam int EW = (PW > etok_pkg::TOK_W) ? PW : etok_pkg::TOK_W;
    localparam logic [PW-1:0] POS_LAST = PW'(TEXT_DEPTH - 1);

    typedef enum logic [1:0] {
        MODE_SEEK,
        MODE_COMMENT,
        MODE_NUMBER,
        MODE_IDENT
    } t_mode;

    t_mode          r_mode,  n_mode;
    logic [PW-1:0]  r_pos,   n_pos;
    logic [PW-1:0]  r_start, n_start;
    logic [1:0]     r_dots,  n_dots;
    logic [1:0]     r_kw,    n_kw;

    logic           accept;
    logic           end_t;
    logic           is_digit, is_letter, is_sep, is_hash, is_dot, is_word;
    logic           num_cont, id_cont, close_en, eff_seek, single_en, sec_en;
    logic [PW-1:0]  idx;
    logic [EW-1:0]  pos_ext, start_ext, len_ext;
    etok_pkg::t_token tok_close, tok_sec;
    etok_pkg::t_kind  close_kind;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;

    always_comb begin
        is_digit  = (i_ch >= 8'h30) && (i_ch <= 8'h39);
        is_letter = ((i_ch >= 8'h61) && (i_ch <= 8'h7A)) ||
                    ((i_ch >= 8'h41) && (i_ch <= 8'h5A));
        is_sep    = (i_ch == etok_pkg::CH_SPACE) || (i_ch == etok_pkg::CH_NL);
        is_hash   = (i_ch == etok_pkg::CH_HASH);
        is_dot    = (i_ch == etok_pkg::CH_DOT);
        is_word   = is_letter || is_digit || (i_ch == etok_pkg::CH_UNDER);
        end_t     = (i_ch == etok_pkg::CH_NUL) || (r_pos >= POS_LAST);

        num_cont  = (r_mode == MODE_NUMBER) && !end_t && (is_digit || is_dot);
        id_cont   = (r_mode == MODE_IDENT) && !end_t && is_word;
        close_en  = ((r_mode == MODE_NUMBER) && !num_cont) ||
                    ((r_mode == MODE_IDENT) && !id_cont);
        eff_seek  = (r_mode == MODE_SEEK) || close_en;
        single_en = !end_t && eff_seek && !is_sep && !is_hash && !is_digit && !is_letter;
        sec_en    = end_t || single_en;

        idx       = r_pos - r_start;
        pos_ext   = EW'(r_pos);
        start_ext = EW'(r_start);
        len_ext   = EW'(idx);

        if (r_mode == MODE_NUMBER) begin
            close_kind = (r_dots < 2'd2) ? etok_pkg::KIND_NUMBER : etok_pkg::KIND_ERROR;
        end else if (r_kw[0] && (idx == PW'(4))) begin
            close_kind = etok_pkg::KIND_EXIT;
        end else if (r_kw[1] && (idx == PW'(5))) begin
            close_kind = etok_pkg::KIND_CLEAR;
        end else begin
            close_kind = etok_pkg::KIND_IDENT;
        end

        tok_close.kind   = close_kind;
        tok_close.start  = start_ext[etok_pkg::TOK_W-1:0];
        tok_close.length = len_ext[etok_pkg::TOK_W-1:0];

        tok_sec.kind   = end_t ? etok_pkg::KIND_END : etok_pkg::single_kind(i_ch);
        tok_sec.start  = pos_ext[etok_pkg::TOK_W-1:0];
        tok_sec.length = etok_pkg::TOK_W'(1);

        o_push        = accept && (close_en || sec_en);
        o_entry.two   = close_en && sec_en;
        o_entry.tok_a = tok_close;
        o_entry.tok_b = sec_en ? tok_sec : tok_close;

        n_mode  = r_mode;
        n_pos   = r_pos + PW'(1);
        n_start = r_start;
        n_dots  = r_dots;
        n_kw    = r_kw;

        if (end_t) begin
            n_mode  = MODE_SEEK;
            n_pos   = '0;
            n_start = '0;
            n_dots  = '0;
            n_kw    = 2'b11;
        end else if (r_mode == MODE_COMMENT) begin
            if (i_ch == etok_pkg::CH_NL) begin
                n_mode = MODE_SEEK;
            end
        end else if (num_cont) begin
            if (is_dot && (r_dots < 2'd2)) begin
                n_dots = r_dots + 2'd1;
            end
        end else if (id_cont) begin
            if (!((idx < PW'(4)) && (i_ch == etok_pkg::exit_char(idx[1:0])))) begin
                n_kw[0] = 1'b0;
            end
            if (!((idx < PW'(5)) && (i_ch == etok_pkg::clear_char(idx[2:0])))) begin
                n_kw[1] = 1'b0;
            end
        end else begin
            n_mode = MODE_SEEK;
            if (is_hash) begin
                n_mode = MODE_COMMENT;
            end else if (is_digit) begin
                n_mode  = MODE_NUMBER;
                n_start = r_pos;
                n_dots  = '0;
            end else if (is_letter) begin
                n_mode  = MODE_IDENT;
                n_start = r_pos;
                n_kw    = {i_ch == etok_pkg::clear_char(3'd0),
                           i_ch == etok_pkg::exit_char(2'd0)};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_SEEK;
            r_pos   <= '0;
            r_start <= '0;
            r_dots  <= '0;
            r_kw    <= 2'b11;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_dots  <= n_dots;
            r_kw    <= n_kw;
        end
    end

`ifndef SYNTHESIS
    a_pos_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_LAST)
        else $error("position passed the text limit");

    a_run_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_NUMBER || r_mode == MODE_IDENT) |-> (r_start < r_pos))
        else $error("open run does not start before the position");

    a_dots_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dots != 2'd3)
        else $error("dot count passed saturation");
`endif

endmodule

### hw/rtl/etok_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etok_queue
// Short token queue between scanner and output stage; one entry holds the
// one or two tokens caused by a single character.
// ----------------------------------------------------------------------------
module etok_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  etok_pkg::t_entry   i_entry,
    input  logic               i_pop,
    output logic               o_full,
    output etok_pkg::t_qstat   o_stat
);

    localparam int AW = $clog2(etok_pkg::QDEPTH);
    localparam int CW = $clog2(etok_pkg::QDEPTH + 1);

    etok_pkg::t_entry r_mem [etok_pkg::QDEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_count;

    assign o_full       = (r_count == CW'(etok_pkg::QDEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_stat.head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("push into a full token queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("pop from an empty token queue");
`endif

endmodule

### hw/rtl/etok_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etok_back
// Output stage: drains queue entries into the registered token port, one
// token per transaction, splitting two-token entries.
// ----------------------------------------------------------------------------
module etok_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  etok_pkg::t_qstat   i_stat,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output etok_pkg::t_token   o_tok,
    output logic               o_last
);

    logic             r_valid;
    logic             r_second;
    logic             r_last;
    etok_pkg::t_token r_tok;
    logic             out_free;
    logic             split;

    assign out_free = !r_valid || !i_stall;
    assign split    = i_stat.head.two && !r_second;
    assign o_pop    = out_free && !i_stat.empty && !split;
    assign o_valid  = r_valid;
    assign o_tok    = r_tok;
    assign o_last   = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (out_free) begin
            if (!i_stat.empty) begin
                r_valid <= 1'b1;
                if (split) begin
                    r_tok    <= i_stat.head.tok_a;
                    r_last   <= 1'b0;
                    r_second <= 1'b1;
                end else begin
                    r_tok    <= i_stat.head.tok_b;
                    r_last   <= 1'b1;
                    r_second <= 1'b0;
                end
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_second_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> (!i_stat.empty && i_stat.head.two && r_valid && !r_last))
        else $error("second token pending without a two-token head entry");
`endif

endmodule

### dv/tb_expression_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_expression_tokenizer
// Self-checking bench for the streaming expression tokenizer.
// ----------------------------------------------------------------------------
// Characters are offered on the input channel and every accepted character is
// run through a cycle-free scanner model kept in this bench. The model's tokens
// are queued in order and each token the block sends is compared with the
// oldest queued one: kind, start offset, length and the last-of-character
// flag. A short table of hand-written characters opens the run, with typed
// tokens where they are obvious (first token, error runs, end of text). Random
// texts of numbers, names, keywords, operators, comments and stray bytes
// follow, then a stretch where the output is held off long enough to back up
// the input, and a final stretch without any gaps on either side.
// ----------------------------------------------------------------------------
module tb_expression_tokenizer;

    localparam int TEXT_DEPTH    = 8192;
    localparam int DIR_LEN       = 28;
    localparam int RANDOM_CHARS  = 1300;
    localparam int HOLD_CYCLES   = 48;
    localparam int QUIET_LIMIT   = 2000;
    localparam int PRINT_LIMIT   = 100;
    localparam string OP_CHARS   = ";()+-*/%=";
    localparam logic [31:0] WORD_EXIT  = "exit";
    localparam logic [39:0] WORD_CLEAR = "clear";

    typedef enum logic [1:0] {
        SCAN_SEEK,
        SCAN_COMMENT,
        SCAN_NUMBER,
        SCAN_IDENT
    } t_scan_mode;

    typedef struct packed {
        etok_pkg::t_kind kind;
        logic [12:0]     start;
        logic [12:0]     len;
        logic            last;
    } t_tok;

    typedef struct packed {
        logic [1:0] count;
        t_tok       first;
        t_tok       second;
    } t_step_out;

    typedef struct packed {
        logic [7:0] ch;
        logic       fixed;
        t_step_out  want;
    } t_dir_row;

    localparam t_tok      NO_TOK    = '0;
    localparam t_step_out NO_RESULT = '0;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_ch    = 8'd0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [3:0]  o_token_kind;
    logic [12:0] o_token_start;
    logic [12:0] o_token_length;
    logic        o_last_of_run;

    t_scan_mode  scan_mode = SCAN_SEEK;
    int          scan_pos  = 0;
    int          run_begin = 0;
    int          dots_seen = 0;
    logic [1:0]  kw_alive  = 2'b11;

    t_tok        pending_tokens[$];
    logic [7:0]  text_buf[$];
    t_dir_row    dir_table[DIR_LEN];

    bit          idling_on     = 1'b1;
    bit          hold_out_req  = 1'b0;
    int          mismatch_count = 0;
    int          tokens_checked = 0;
    int          chars_sent     = 0;
    int          texts_sent     = 0;
    int          input_stalls   = 0;
    int          quiet_cycles   = 0;

    expression_tokenizer #(
        .TEXT_DEPTH(TEXT_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_ch           (i_ch),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_token_kind   (o_token_kind),
        .o_token_start  (o_token_start),
        .o_token_length (o_token_length),
        .o_last_of_run  (o_last_of_run)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic etok_pkg::t_kind op_kind(input logic [7:0] c);
        case (c)
            "+":               return etok_pkg::KIND_ADD;
            "-":               return etok_pkg::KIND_SUB;
            "*":               return etok_pkg::KIND_MUL;
            "/":               return etok_pkg::KIND_DIV;
            "%":               return etok_pkg::KIND_MOD;
            "(":               return etok_pkg::KIND_OPEN;
            ")":               return etok_pkg::KIND_CLOSE;
            etok_pkg::CH_SEMI: return etok_pkg::KIND_SEMI;
            "=":               return etok_pkg::KIND_EQUAL;
            default:           return etok_pkg::KIND_ERROR;
        endcase
    endfunction

    function automatic t_step_out add_token(input t_step_out r, input etok_pkg::t_kind k,
                                            input int start, input int len);
        t_tok t;
        t.kind  = k;
        t.start = start[12:0];
        t.len   = len[12:0];
        t.last  = 1'b1;
        if (r.count == 2'd0) begin
            r.first = t;
        end else begin
            r.first.last = 1'b0;
            r.second     = t;
        end
        r.count++;
        return r;
    endfunction

    function automatic etok_pkg::t_kind run_kind(input int len);
        if (scan_mode == SCAN_NUMBER)
            return (dots_seen < 2) ? etok_pkg::KIND_NUMBER : etok_pkg::KIND_ERROR;
        if (kw_alive[1] && len == 5) return etok_pkg::KIND_CLEAR;
        if (kw_alive[0] && len == 4) return etok_pkg::KIND_EXIT;
        return etok_pkg::KIND_IDENT;
    endfunction

    function automatic void reset_scanner();
        scan_mode = SCAN_SEEK;
        scan_pos  = 0;
        run_begin = 0;
        dots_seen = 0;
        kw_alive  = 2'b11;
    endfunction

    function automatic t_step_out next_tokens(input logic [7:0] c);
        t_step_out r;
        logic      at_end;
        int        idx;
        r      = NO_RESULT;
        at_end = (c == etok_pkg::CH_NUL) || (scan_pos >= TEXT_DEPTH - 1);
        if (scan_mode == SCAN_COMMENT && !at_end) begin
            if (c == etok_pkg::CH_NL) scan_mode = SCAN_SEEK;
            scan_pos++;
            return r;
        end
        if (scan_mode == SCAN_NUMBER) begin
            if (!at_end && (is_digit(c) || c == etok_pkg::CH_DOT)) begin
                if (c == etok_pkg::CH_DOT && dots_seen < 2) dots_seen++;
                scan_pos++;
                return r;
            end
            r = add_token(r, run_kind(scan_pos - run_begin), run_begin, scan_pos - run_begin);
            scan_mode = SCAN_SEEK;
        end
        if (scan_mode == SCAN_IDENT) begin
            if (!at_end && (is_letter(c) || is_digit(c) || c == etok_pkg::CH_UNDER)) begin
                idx = scan_pos - run_begin;
                if (kw_alive[0] && !(idx < 4 && c == WORD_EXIT[31 - 8 * idx -: 8]))
                    kw_alive[0] = 1'b0;
                if (kw_alive[1] && !(idx < 5 && c == WORD_CLEAR[39 - 8 * idx -: 8]))
                    kw_alive[1] = 1'b0;
                scan_pos++;
                return r;
            end
            r = add_token(r, run_kind(scan_pos - run_begin), run_begin, scan_pos - run_begin);
            scan_mode = SCAN_SEEK;
        end
        if (at_end) begin
            r = add_token(r, etok_pkg::KIND_END, scan_pos, 1);
            reset_scanner();
            return r;
        end
        if (c != etok_pkg::CH_SPACE && c != etok_pkg::CH_NL) begin
            if (c == etok_pkg::CH_HASH) begin
                scan_mode = SCAN_COMMENT;
            end else if (is_digit(c)) begin
                scan_mode = SCAN_NUMBER;
                run_begin = scan_pos;
                dots_seen = 0;
            end else if (is_letter(c)) begin
                scan_mode = SCAN_IDENT;
                run_begin = scan_pos;
                kw_alive  = {c == "c", c == "e"};
            end else begin
                r = add_token(r, op_kind(c), scan_pos, 1);
            end
        end
        scan_pos++;
        return r;
    endfunction

    function automatic void queue_tokens(input t_step_out r);
        if (r.count >= 2'd1) pending_tokens.push_back(r.first);
        if (r.count == 2'd2) pending_tokens.push_back(r.second);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    task automatic offer_char(input logic [7:0] c);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_ch    <= c;
        do @(posedge i_clk); while (o_stall);
        chars_sent++;
    endtask

    task automatic send_char(input logic [7:0] c);
        offer_char(c);
        queue_tokens(next_tokens(c));
    endtask

    task automatic send_text();
        foreach (text_buf[i]) send_char(text_buf[i]);
        texts_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_tokens.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_digit();
        return 8'(int'("0") + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1)) return 8'(int'("a") + $urandom_range(0, 25));
        return 8'(int'("A") + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_word_char();
        case ($urandom_range(0, 5))
            0:       return rand_digit();
            1:       return etok_pkg::CH_UNDER;
            default: return rand_letter();
        endcase
    endfunction

    function automatic string pick_word();
        case ($urandom_range(0, 9))
            0, 1:    return "exit";
            2, 3:    return "clear";
            4:       return "exi";
            5:       return "exits";
            6:       return "clea";
            7:       return "clears";
            8:       return "Exit";
            default: return "c_ear";
        endcase
    endfunction

    function automatic logic [7:0] rand_separator();
        return $urandom_range(0, 2) == 0 ? etok_pkg::CH_NL : etok_pkg::CH_SPACE;
    endfunction

    task automatic build_text();
        string      w;
        logic [7:0] b;
        text_buf.delete();
        repeat ($urandom_range(1, 16)) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    text_buf.push_back(rand_digit());
                    repeat ($urandom_range(0, 5))
                        text_buf.push_back($urandom_range(0, 3) == 0 ?
                                           etok_pkg::CH_DOT : rand_digit());
                end
                2, 3: begin
                    if ($urandom_range(0, 1)) begin
                        w = pick_word();
                        for (int i = 0; i < w.len(); i++) text_buf.push_back(w[i]);
                    end else begin
                        text_buf.push_back(rand_letter());
                        repeat ($urandom_range(0, 7)) text_buf.push_back(rand_word_char());
                    end
                end
                4, 5: text_buf.push_back(OP_CHARS[$urandom_range(0, 8)]);
                6: begin
                    text_buf.push_back(etok_pkg::CH_HASH);
                    repeat ($urandom_range(0, 6)) begin
                        b = 8'($urandom_range(1, 255));
                        text_buf.push_back(b == etok_pkg::CH_NL ? etok_pkg::CH_SPACE : b);
                    end
                    if ($urandom_range(0, 5) != 0) text_buf.push_back(etok_pkg::CH_NL);
                end
                7: text_buf.push_back(8'($urandom_range(1, 255)));
                default: text_buf.push_back(rand_separator());
            endcase
            if ($urandom_range(0, 1)) text_buf.push_back(rand_separator());
        end
        text_buf.push_back(etok_pkg::CH_NUL);
    endtask

    always @(posedge i_clk) begin : check_tokens
        t_tok got;
        t_tok want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {etok_pkg::t_kind'(o_token_kind), o_token_start, o_token_length,
                   o_last_of_run};
            if (pending_tokens.size() == 0) begin
                report_mismatch($sformatf("unexpected token kind %0d start %0d len %0d last %0d",
                                          got.kind, got.start, got.len, got.last));
            end else begin
                want = pending_tokens.pop_front();
                tokens_checked++;
                if (got !== want)
                    report_mismatch($sformatf(
                        "kind %0d/%0d start %0d/%0d len %0d/%0d last %0d/%0d (got/want)",
                        got.kind, want.kind, got.start, want.start,
                        got.len, want.len, got.last, want.last));
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_valid && o_stall) input_stalls++;
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Timeout: no transaction for %0d cycles, %0d tokens pending",
                         quiet_cycles, pending_tokens.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_out_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_out_req = 1'b0;
                i_stall <= 1'b0;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge i_clk);
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin : run_stimulus
        t_step_out predicted;
        dir_table = '{
            '{"(",    1'b1, '{2'd1, '{etok_pkg::KIND_OPEN, 13'd0, 13'd1, 1'b1}, NO_TOK}},
            '{"1",    1'b0, NO_RESULT},
            '{etok_pkg::CH_DOT, 1'b0, NO_RESULT},
            '{"5",    1'b0, NO_RESULT},
            '{")",    1'b0, NO_RESULT},
            '{"9",    1'b0, NO_RESULT},
            '{etok_pkg::CH_DOT, 1'b0, NO_RESULT},
            '{etok_pkg::CH_DOT, 1'b0, NO_RESULT},
            '{"-",    1'b1, '{2'd2, '{etok_pkg::KIND_ERROR, 13'd5, 13'd3, 1'b0},
                                    '{etok_pkg::KIND_SUB, 13'd8, 13'd1, 1'b1}}},
            '{"e",    1'b0, NO_RESULT},
            '{"x",    1'b0, NO_RESULT},
            '{"i",    1'b0, NO_RESULT},
            '{"t",    1'b0, NO_RESULT},
            '{"*",    1'b0, NO_RESULT},
            '{"c",    1'b0, NO_RESULT},
            '{"l",    1'b0, NO_RESULT},
            '{"e",    1'b0, NO_RESULT},
            '{"a",    1'b0, NO_RESULT},
            '{"r",    1'b0, NO_RESULT},
            '{"/",    1'b0, NO_RESULT},
            '{"%",    1'b0, NO_RESULT},
            '{"=",    1'b0, NO_RESULT},
            '{"+",    1'b0, NO_RESULT},
            '{etok_pkg::CH_SEMI, 1'b0, NO_RESULT},
            '{8'h09,  1'b1,
              '{2'd1, '{etok_pkg::KIND_ERROR, 13'd24, 13'd1, 1'b1}, NO_TOK}},
            '{etok_pkg::CH_HASH, 1'b0, NO_RESULT},
            '{8'hFF,  1'b0, NO_RESULT},
            '{etok_pkg::CH_NUL, 1'b1,
              '{2'd1, '{etok_pkg::KIND_END, 13'd27, 13'd1, 1'b1}, NO_TOK}}
        };

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_LEN; i++) begin
            offer_char(dir_table[i].ch);
            predicted = next_tokens(dir_table[i].ch);
            queue_tokens(dir_table[i].fixed ? dir_table[i].want : predicted);
        end

        while (chars_sent < DIR_LEN + RANDOM_CHARS) begin
            idling_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0) wait_drained();
            build_text();
            send_text();
        end

        // hold the output while operators keep arriving
        wait_drained();
        idling_on    = 1'b0;
        hold_out_req = 1'b1;
        text_buf.delete();
        repeat (40) text_buf.push_back(OP_CHARS[$urandom_range(0, 8)]);
        text_buf.push_back(etok_pkg::CH_NUL);
        send_text();
        wait_drained();

        repeat (6) begin
            build_text();
            send_text();
        end

        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("Sent %0d characters in %0d texts, checked %0d tokens.",
                 chars_sent, texts_sent, tokens_checked);
        $display("Input held back for %0d cycles; %0d mismatches.",
                 input_stalls, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
